### rtl/assert_macros.svh
// Assertion macros used by the top level; clock clk, synchronous reset rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pum_pkg.sv
// Package of the per-user event rate monitor: sizes, codes, types and helpers.
package pum_pkg;

  localparam int USER_COUNT     = 1024;
  localparam int COUNT_BITS     = 16;
  localparam int ADDR_BITS      = $clog2(USER_COUNT);
  localparam int USER_BITS      = 10;
  localparam int KIND_BITS      = 2;
  localparam int LIMIT_BITS     = 16;
  localparam int TOTAL_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CMP_BITS       = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;

  localparam logic [LIMIT_BITS-1:0] MESSAGE_LIMIT_RESET    = LIMIT_BITS'(5);
  localparam logic [LIMIT_BITS-1:0] JOIN_LEAVE_LIMIT_RESET = LIMIT_BITS'(3);
  localparam logic [LIMIT_BITS-1:0] MENTION_LIMIT_RESET    = LIMIT_BITS'(10);

  typedef enum logic {
    FUNC_RECORD = 1'b0,
    FUNC_CHECK  = 1'b1
  } func_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_JOIN    = 2'd0,
    KIND_LEAVE   = 2'd1,
    KIND_MESSAGE = 2'd2,
    KIND_MENTION = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MESSAGE_LIMIT    = 2'd0,
    CFG_JOIN_LEAVE_LIMIT = 2'd1,
    CFG_MENTION_LIMIT    = 2'd2
  } cfg_index_t;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LIMIT_BITS-1:0] limit_t;
  typedef logic [TOTAL_BITS-1:0] total_t;

  // One table word per user.
  typedef struct packed {
    logic   active;
    count_t message;
    count_t join_leave;
    count_t mention;
  } entry_t;

  typedef struct packed {
    limit_t message;
    limit_t join_leave;
    limit_t mention;
  } limits_t;

  // Saturating increment.
  function automatic count_t bump(count_t c);
    return (c == '1) ? c : count_t'(c + 1'b1);
  endfunction

  // Total as reported, clamped to the field.
  function automatic total_t report(count_t c);
    logic [CMP_BITS-1:0] w;
    w = CMP_BITS'(c);
    if (w > CMP_BITS'({TOTAL_BITS{1'b1}})) return '1;
    return TOTAL_BITS'(w);
  endfunction

  function automatic logic above(count_t c, limit_t lim);
    return CMP_BITS'(c) > CMP_BITS'(lim);
  endfunction

endpackage

### rtl/pum_ifs.sv
// Valid/ready channel interfaces: event items, check results, register writes.
interface pum_item_if;
  import pum_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [USER_BITS-1:0] user_index;
  logic [KIND_BITS-1:0] event_kind;
  modport source (output valid, func, user_index, event_kind, input ready);
  modport sink   (input valid, func, user_index, event_kind, output ready);
endinterface

interface pum_result_if;
  import pum_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [USER_BITS-1:0]  checked_user;
  logic                  user_active;
  logic                  message_over;
  logic                  join_leave_over;
  logic                  mention_over;
  logic [TOTAL_BITS-1:0] message_total;
  logic [TOTAL_BITS-1:0] join_leave_total;
  logic [TOTAL_BITS-1:0] mention_total;
  modport source (output valid, checked_user, user_active, message_over, join_leave_over,
                  mention_over, message_total, join_leave_total, mention_total,
                  input ready);
  modport sink   (input valid, checked_user, user_active, message_over, join_leave_over,
                  mention_over, message_total, join_leave_total, mention_total,
                  output ready);
endinterface

interface pum_cfg_if;
  import pum_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [LIMIT_BITS-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/per_user_event_rate_monitor_top.sv
// Top level of the per-user event rate monitor: table pipeline, clear pass, result register.
// Keeps one table word per user (active mark plus saturating join/leave, message and
// mention counters) in a single synchronous RAM. A record item (func 0) marks its user
// active, zeroes the counters on the first event since reset and bumps the counter the
// event kind selects; it returns nothing. A check item (func 1) returns one result with
// the user's mark, the three totals and the over-limit flags, then clears that user's
// counters. Sustained rate is one item per cycle: each item is a RAM read issued at its
// transfer and a write-back as it leaves stage 1, with the previous write forwarded when
// both hit the same user. A check's result is loaded into the output register as the
// check leaves stage 1; outside the clear pass the input only stalls while a check waits
// on a full output register. After reset a clear pass writes all USER_COUNT (1024) table
// entries, one per cycle; no items are taken during it, register writes are.
`include "assert_macros.svh"

module per_user_event_rate_monitor_top (
  input  logic          clk,
  input  logic          rst,
  pum_item_if.sink      items,
  pum_result_if.source  results,
  pum_cfg_if.sink       cfg
);
  import pum_pkg::*;

  limits_t limits;

  pum_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .limits (limits)
  );

  // Clear pass
  logic                 clearing;
  logic [ADDR_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= ADDR_BITS'(clr_addr + 1'b1);
      if (clr_addr == ADDR_BITS'(USER_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Stage 1: item waiting on its RAM read
  logic                 s1_valid;
  logic                 s1_func;
  logic [USER_BITS-1:0] s1_user;
  logic [KIND_BITS-1:0] s1_kind;
  logic                 s1_in_range;
  logic [ADDR_BITS-1:0] s1_addr;

  // Last write-back, captured when the stage-1 item issued its read
  logic                 wb_valid;
  logic [ADDR_BITS-1:0] wb_addr;
  entry_t               wb_data;

  // Result register
  logic                 res_valid;

  logic   accept;
  logic   s1_is_check;
  logic   s1_adv;
  logic   act;
  logic   wr_needed;
  logic   wb_en;
  entry_t rd_entry;
  entry_t cur;
  entry_t upd;

  assign s1_addr     = ADDR_BITS'(s1_user);
  assign s1_is_check = (s1_func == FUNC_CHECK);
  assign s1_adv      = !s1_is_check || !res_valid || results.ready;
  assign items.ready = !clearing && (!s1_valid || s1_adv);
  assign accept      = items.valid && items.ready;

  // Forward the write that landed at the same edge as this item's read.
  assign cur = (wb_valid && (wb_addr == s1_addr)) ? wb_data : rd_entry;
  assign act = s1_in_range && cur.active;

  always_comb begin
    upd       = cur;
    wr_needed = 1'b0;
    if (!s1_is_check) begin
      if (s1_in_range) begin
        wr_needed  = 1'b1;
        upd.active = 1'b1;
        if (!cur.active) begin
          upd.message    = '0;
          upd.join_leave = '0;
          upd.mention    = '0;
        end
        case (s1_kind) inside
          KIND_JOIN, KIND_LEAVE: upd.join_leave = bump(upd.join_leave);
          KIND_MESSAGE:          upd.message    = bump(upd.message);
          default:               upd.mention    = bump(upd.mention);
        endcase
      end
    end else if (act) begin
      // mark stays set, counters restart
      wr_needed      = 1'b1;
      upd.message    = '0;
      upd.join_leave = '0;
      upd.mention    = '0;
    end
  end

  assign wb_en = s1_valid && s1_adv && wr_needed;

  pum_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (USER_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (clearing || wb_en),
    .waddr (clearing ? clr_addr : s1_addr),
    .wdata (clearing ? entry_t'('0) : upd),
    .re    (accept),
    .raddr (ADDR_BITS'(items.user_index)),
    .rdata (rd_entry)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      wb_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        wb_valid <= wb_en;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_is_check && s1_adv) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func     <= items.func;
      s1_user     <= items.user_index;
      s1_kind     <= items.event_kind;
      s1_in_range <= (32'(items.user_index) < USER_COUNT);
      wb_addr     <= s1_addr;
      wb_data     <= upd;
    end
    if (s1_valid && s1_is_check && s1_adv) begin
      results.checked_user     <= s1_user;
      results.user_active      <= act;
      results.message_over     <= act && above(cur.message, limits.message);
      results.join_leave_over  <= act && above(cur.join_leave, limits.join_leave);
      results.mention_over     <= act && above(cur.mention, limits.mention);
      results.message_total    <= act ? report(cur.message) : '0;
      results.join_leave_total <= act ? report(cur.join_leave) : '0;
      results.mention_total    <= act ? report(cur.mention) : '0;
    end
  end

  assign results.valid = res_valid;

  // Checks
  `ASSERT_IMP(a_no_wb_in_clear, clearing, !wb_en, "write-back during clear pass")
  `ASSERT_IMP(a_clear_ends_last, $fell(clearing),
              $past(clr_addr) == ADDR_BITS'(USER_COUNT - 1), "clear pass ended early")
  `ASSERT_IMP(a_result_from_check, $rose(res_valid),
              $past(s1_valid && s1_func == FUNC_CHECK), "result without a check")
  `ASSERT_NXT(a_check_enters_s1, accept && items.func == FUNC_CHECK,
              s1_valid && s1_func == FUNC_CHECK, "check transfer lost")

endmodule

### rtl/pum_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read before write on a same-address collision.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pum_cfg.sv
// Threshold registers written through the configuration channel.
module pum_cfg (
  input  logic              clk,
  input  logic              rst,
  pum_cfg_if.sink           cfg,
  output pum_pkg::limits_t  limits
);
  import pum_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.message    <= MESSAGE_LIMIT_RESET;
      limits.join_leave <= JOIN_LEAVE_LIMIT_RESET;
      limits.mention    <= MENTION_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MESSAGE_LIMIT:    limits.message    <= cfg.data;
        CFG_JOIN_LEAVE_LIMIT: limits.join_leave <= cfg.data;
        CFG_MENTION_LIMIT:    limits.mention    <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule
